/* hdl/e2b_pkg.sv */
// shared types, constants and the cordic angle table for the euler basis block
// no dependencies
package e2b_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 14;
    localparam int IN_BITS       = 16;
    localparam int OUT_BITS      = 16;
    localparam int CORDIC_STEPS  = 28;
    localparam int CW            = 34;   // cordic x/y width, q30 with headroom
    localparam int ZW            = 32;   // residual angle width, 32-bit turn scale
    localparam int VW            = 32;   // sine/cosine width, q30
    localparam int PW            = 64;   // product width, q60
    localparam int QUEUE_DEPTH   = 4;    // power of two
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [VW-1:0] ONE_Q30     = VW'(1073741824);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0]             quad;
        logic signed [ZW-1:0]   resid;
    } t_angle;

    typedef struct packed {
        t_angle yaw;
        t_angle pitch;
        t_angle roll;
    } t_triple;

    typedef struct packed {
        logic signed [VW-1:0] c;
        logic signed [VW-1:0] s;
    } t_sincos;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] right_x;
        logic signed [OUT_BITS-1:0] right_y;
        logic signed [OUT_BITS-1:0] right_z;
        logic signed [OUT_BITS-1:0] up_x;
        logic signed [OUT_BITS-1:0] up_y;
        logic signed [OUT_BITS-1:0] up_z;
        logic signed [OUT_BITS-1:0] forward_x;
        logic signed [OUT_BITS-1:0] forward_y;
        logic signed [OUT_BITS-1:0] forward_z;
    } t_result;

    // atan(2^-i) on the 32-bit turn scale
    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335086;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/euler_to_basis_vectors.sv */
// euler_to_basis_vectors: yaw/pitch/roll angles in, rotated right, up and
// forward unit vectors out (q1.14). uses e2b_pkg, e2b_front, e2b_cordic, e2b_matrix
//
// usage
//   input channel: drive the three binary angles (65536 = one turn) and raise
//   i_push; a transaction happens on a clock edge with i_push high and o_full
//   low. the front end folds each angle to a quadrant and residue and queues
//   the triple in a four-entry queue
//   result channel: while o_empty is low the oldest result sits on the o_*
//   ports; a transaction happens on an edge with i_pop high and o_empty low
//   path to o_empty low: queue written on the transaction edge, then the
//   cordic load stage, 28 cordic step stages and five matrix stages; all
//   of these stages hold while the back end stalls
//   throughput: one transaction per cycle on each side while o_full and
//   o_empty allow; the 28-stage cordic pipelines (one per angle), ten pair
//   and four triple multipliers take a new item every cycle they advance
//   reset: synchronous, active low; queue and all stage valid bits clear, so
//   o_empty is high and o_full low after reset
//   stall: while a result is held and i_pop stays low, the whole back end
//   freezes; the queue keeps taking transactions until it fills, then o_full
//   rises
module euler_to_basis_vectors (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [15:0]        i_yaw_angle,
    input  logic [15:0]        i_pitch_angle,
    input  logic [15:0]        i_roll_angle,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic signed [15:0] o_forward_x,
    output logic signed [15:0] o_forward_y,
    output logic signed [15:0] o_forward_z
);

    logic              head_valid;
    e2b_pkg::t_triple  head;
    logic              adv;         // back end moves one step
    logic              out_valid;
    logic              v_yaw, v_pitch, v_roll;
    e2b_pkg::t_sincos  sc_yaw, sc_pitch, sc_roll;
    e2b_pkg::t_result  res;

    // back end advances unless a result is held and not being taken
    assign adv     = !out_valid || i_pop;
    assign o_empty = !out_valid;

    e2b_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_roll_angle  (i_roll_angle),
        .o_full        (o_full),
        .i_take        (adv),
        .o_head_valid  (head_valid),
        .o_head        (head)
    );

    // one cordic pipeline per angle, all in lock step
    e2b_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (head_valid),
        .i_ang   (head.yaw),
        .o_valid (v_yaw),
        .o_sc    (sc_yaw)
    );

    e2b_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (head_valid),
        .i_ang   (head.pitch),
        .o_valid (v_pitch),
        .o_sc    (sc_pitch)
    );

    e2b_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (head_valid),
        .i_ang   (head.roll),
        .o_valid (v_roll),
        .o_sc    (sc_roll)
    );

    e2b_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (v_yaw && v_pitch && v_roll),
        .i_yaw   (sc_yaw),
        .i_pitch (sc_pitch),
        .i_roll  (sc_roll),
        .o_valid (out_valid),
        .o_res   (res)
    );

    assign o_right_x   = res.right_x;
    assign o_right_y   = res.right_y;
    assign o_right_z   = res.right_z;
    assign o_up_x      = res.up_x;
    assign o_up_y      = res.up_y;
    assign o_up_z      = res.up_z;
    assign o_forward_x = res.forward_x;
    assign o_forward_y = res.forward_y;
    assign o_forward_z = res.forward_z;

    // the three angle pipelines must never drift apart
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_yaw == v_pitch) && (v_pitch == v_roll))
        else $error("cordic pipelines out of step");

    // a held result is not replaced while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !i_pop) |=> (out_valid && $stable(res)))
        else $error("result changed during stall");

endmodule

/* hdl/e2b_front.sv */
// front end: accepts angle triples, splits each into quadrant and residue,
// and holds them in a short queue. depends on e2b_pkg
module e2b_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [15:0]          i_yaw_angle,
    input  logic [15:0]          i_pitch_angle,
    input  logic [15:0]          i_roll_angle,
    output logic                 o_full,
    input  logic                 i_take,
    output logic                 o_head_valid,
    output e2b_pkg::t_triple     o_head
);

    function automatic e2b_pkg::t_angle classify(input logic [15:0] a);
        logic [31:0]     ext;
        logic [31:0]     a32;
        logic [31:0]     t;
        e2b_pkg::t_angle r;
        ext     = 32'(a) & ((32'd1 << e2b_pkg::ANGLE_BITS) - 32'd1);
        a32     = ext << (32 - e2b_pkg::ANGLE_BITS);
        t       = a32 + 32'h2000_0000;
        r.quad  = t[31:30];
        r.resid = $signed({2'b00, t[29:0]}) - 32'sd536870912;
        return r;
    endfunction

    function automatic logic [e2b_pkg::QCNT_BITS-1:0] QCNT_ONE(input logic b);
        return e2b_pkg::QCNT_BITS'(b);
    endfunction

    e2b_pkg::t_triple               r_mem [e2b_pkg::QUEUE_DEPTH];
    logic [e2b_pkg::QPTR_BITS-1:0]  r_wp;
    logic [e2b_pkg::QPTR_BITS-1:0]  r_rp;
    logic [e2b_pkg::QCNT_BITS-1:0]  r_count;
    logic                           do_push;
    logic                           do_pop;
    e2b_pkg::t_triple               n_entry;

    assign o_full       = (r_count == e2b_pkg::QCNT_BITS'(e2b_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rp];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_take && o_head_valid;

    always_comb begin
        n_entry.yaw   = classify(i_yaw_angle);
        n_entry.pitch = classify(i_pitch_angle);
        n_entry.roll  = classify(i_roll_angle);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_ONE(do_push) - QCNT_ONE(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= e2b_pkg::QCNT_BITS'(e2b_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

/* hdl/e2b_cordic.sv */
// pipelined rotation-mode cordic, one step per stage, with quadrant fold-back
// and clamp at the end. depends on e2b_pkg
module e2b_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  e2b_pkg::t_angle      i_ang,
    output logic                 o_valid,
    output e2b_pkg::t_sincos     o_sc
);

    localparam int N = e2b_pkg::CORDIC_STEPS;

    logic signed [e2b_pkg::CW-1:0] r_x [N+1];
    logic signed [e2b_pkg::CW-1:0] r_y [N+1];
    logic signed [e2b_pkg::ZW-1:0] r_z [N+1];
    logic [1:0]                    r_q [N+1];
    logic                          r_v [N+1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0] <= e2b_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= i_ang.resid;
            r_q[0] <= i_ang.quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic signed [e2b_pkg::CW-1:0] dx;
        logic signed [e2b_pkg::CW-1:0] dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - e2b_pkg::atan_turn(g);
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + e2b_pkg::atan_turn(g);
                end
                r_q[g+1] <= r_q[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[g+1] <= r_v[g];
            end
        end
    end

    function automatic logic signed [e2b_pkg::VW-1:0] clamp(
        input logic signed [e2b_pkg::CW-1:0] v);
        logic signed [e2b_pkg::CW-1:0] one;
        logic signed [e2b_pkg::CW-1:0] r;
        one = e2b_pkg::CW'(e2b_pkg::ONE_Q30);
        r   = v;
        if (v > one) begin
            r = one;
        end else if (v < -one) begin
            r = -one;
        end
        return r[e2b_pkg::VW-1:0];
    endfunction

    logic signed [e2b_pkg::CW-1:0] c_raw;
    logic signed [e2b_pkg::CW-1:0] s_raw;

    always_comb begin
        unique case (r_q[N])
            e2b_pkg::QUAD_0: begin
                c_raw = r_x[N];
                s_raw = r_y[N];
            end
            e2b_pkg::QUAD_1: begin
                c_raw = -r_y[N];
                s_raw = r_x[N];
            end
            e2b_pkg::QUAD_2: begin
                c_raw = -r_x[N];
                s_raw = -r_y[N];
            end
            default: begin
                c_raw = r_y[N];
                s_raw = -r_x[N];
            end
        endcase
    end

    assign o_sc.c  = clamp(c_raw);
    assign o_sc.s  = clamp(s_raw);
    assign o_valid = r_v[N];

endmodule

/* hdl/e2b_matrix.sv */
// back end: forms the nine rotation matrix terms from the sines and cosines,
// rounds, saturates and holds the result. depends on e2b_pkg
module e2b_matrix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  e2b_pkg::t_sincos     i_yaw,
    input  e2b_pkg::t_sincos     i_pitch,
    input  e2b_pkg::t_sincos     i_roll,
    output logic                 o_valid,
    output e2b_pkg::t_result     o_res
);

    localparam int VW = e2b_pkg::VW;
    localparam int PW = e2b_pkg::PW;
    localparam int RS = 60 - e2b_pkg::FRACTION_BITS;

    function automatic logic signed [VW-1:0] rnd30(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + (PW'(1) <<< 29)) >>> 30;
        return r[VW-1:0];
    endfunction

    function automatic logic signed [e2b_pkg::OUT_BITS-1:0] finish(
        input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        logic signed [PW-1:0] one;
        one = PW'(1) <<< e2b_pkg::FRACTION_BITS;
        r   = (v + (PW'(1) <<< (RS - 1))) >>> RS;
        if (r > one) begin
            r = one;
        end else if (r < -one) begin
            r = -one;
        end
        return r[e2b_pkg::OUT_BITS-1:0];
    endfunction

    // stage 0: registered sines and cosines
    logic                 r0_v;
    logic signed [VW-1:0] r0_cy, r0_sy, r0_cp, r0_sp, r0_cr, r0_sr;
    // stage 1: pair products
    logic                 r1_v;
    logic signed [PW-1:0] r1_cycr, r1_sysp, r1_cysp, r1_cpsr, r1_cpcr;
    logic signed [PW-1:0] r1_sycp, r1_cycp, r1_sycr, r1_cysr, r1_sysr;
    logic signed [VW-1:0] r1_sr, r1_cr, r1_sp;
    // stage 2: triple products
    logic                 r2_v;
    logic signed [PW-1:0] r2_cycr, r2_cpsr, r2_cpcr, r2_sycp, r2_cycp;
    logic signed [PW-1:0] r2_sycr, r2_cysr, r2_sysr;
    logic signed [PW-1:0] r2_t_sysr_s, r2_t_cysr_s, r2_t_syc_r, r2_t_cyc_r;
    logic signed [VW-1:0] r2_sp;
    // stage 3: sums in q60
    logic                 r3_v;
    logic signed [PW-1:0] r3_rx, r3_ry, r3_rz, r3_ux, r3_uy, r3_uz;
    logic signed [PW-1:0] r3_fx, r3_fy, r3_fz;
    // stage 4: result register
    logic                 r4_v;
    e2b_pkg::t_result     r4_res;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_cy <= i_yaw.c;
            r0_sy <= i_yaw.s;
            r0_cp <= i_pitch.c;
            r0_sp <= i_pitch.s;
            r0_cr <= i_roll.c;
            r0_sr <= i_roll.s;

            r1_cycr <= r0_cy * r0_cr;
            r1_sysp <= r0_sy * r0_sp;
            r1_cysp <= r0_cy * r0_sp;
            r1_cpsr <= r0_cp * r0_sr;
            r1_cpcr <= r0_cp * r0_cr;
            r1_sycp <= r0_sy * r0_cp;
            r1_cycp <= r0_cy * r0_cp;
            r1_sycr <= r0_sy * r0_cr;
            r1_cysr <= r0_cy * r0_sr;
            r1_sysr <= r0_sy * r0_sr;
            r1_sr   <= r0_sr;
            r1_cr   <= r0_cr;
            r1_sp   <= r0_sp;

            r2_cycr     <= r1_cycr;
            r2_cpsr     <= r1_cpsr;
            r2_cpcr     <= r1_cpcr;
            r2_sycp     <= r1_sycp;
            r2_cycp     <= r1_cycp;
            r2_sycr     <= r1_sycr;
            r2_cysr     <= r1_cysr;
            r2_sysr     <= r1_sysr;
            r2_t_sysr_s <= rnd30(r1_sysp) * r1_sr;
            r2_t_cysr_s <= rnd30(r1_cysp) * r1_sr;
            r2_t_syc_r  <= rnd30(r1_sysp) * r1_cr;
            r2_t_cyc_r  <= rnd30(r1_cysp) * r1_cr;
            r2_sp       <= r1_sp;

            r3_rx <= r2_cycr + r2_t_sysr_s;
            r3_ry <= r2_cpsr;
            r3_rz <= r2_t_cysr_s - r2_sycr;
            r3_ux <= r2_t_syc_r - r2_cysr;
            r3_uy <= r2_cpcr;
            r3_uz <= r2_sysr + r2_t_cyc_r;
            r3_fx <= r2_sycp;
            r3_fy <= -(PW'(r2_sp) <<< 30);
            r3_fz <= r2_cycp;

            r4_res.right_x   <= finish(r3_rx);
            r4_res.right_y   <= finish(r3_ry);
            r4_res.right_z   <= finish(r3_rz);
            r4_res.up_x      <= finish(r3_ux);
            r4_res.up_y      <= finish(r3_uy);
            r4_res.up_z      <= finish(r3_uz);
            r4_res.forward_x <= finish(r3_fx);
            r4_res.forward_y <= finish(r3_fy);
            r4_res.forward_z <= finish(r3_fz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_res   = r4_res;

endmodule
